// ----- hdl/npn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npn_pkg
// Shared types, widths, masks and field helpers for the NPN transform unit.
// ----------------------------------------------------------------------------
package npn_pkg;

  localparam int KIND_W  = 2;
  localparam int TABLE_W = 16;
  localparam int XFORM_W = 13;
  localparam int NVARS   = 4;
  localparam int PERM_W  = 2 * NVARS;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_APPLY   = 2'd0,
    KIND_COMPOSE = 2'd1,
    KIND_INVERT  = 2'd2
  } kind_t;

  // half-swap masks, one pair per input variable
  localparam logic [TABLE_W-1:0] MASK_ALL  = 16'hFFFF;
  localparam logic [TABLE_W-1:0] MASK_V0_H = 16'hAAAA;
  localparam logic [TABLE_W-1:0] MASK_V0_L = 16'h5555;
  localparam logic [TABLE_W-1:0] MASK_V1_H = 16'hCCCC;
  localparam logic [TABLE_W-1:0] MASK_V1_L = 16'h3333;
  localparam logic [TABLE_W-1:0] MASK_V2_H = 16'hF0F0;
  localparam logic [TABLE_W-1:0] MASK_V2_L = 16'h0F0F;
  localparam logic [TABLE_W-1:0] MASK_V3_H = 16'hFF00;
  localparam logic [TABLE_W-1:0] MASK_V3_L = 16'h00FF;

  // stage 1 word: negated table and raw transforms
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TABLE_W-1:0] table_neg;
    logic [XFORM_W-1:0] xform_a;
    logic [XFORM_W-1:0] xform_b;
    logic               bad_a;
    logic               bad_b;
  } s1_t;

  // stage 2 word: candidate results before selection
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TABLE_W-1:0] table_perm;
    logic [XFORM_W-1:0] word_comp;
    logic [XFORM_W-1:0] word_inv;
    logic               bad_a;
    logic               bad_b;
  } s2_t;

  // input negation flag of variable i
  function automatic logic tf_neg(input logic [XFORM_W-1:0] t, input logic [1:0] i);
    tf_neg = t[3'd1 + 3'(i)];
  endfunction

  // permutation target of variable i
  function automatic logic [1:0] tf_perm(input logic [XFORM_W-1:0] t, input logic [1:0] i);
    tf_perm = t[4'd5 + {i, 1'b0} +: 2];
  endfunction

  // true when the four targets form a permutation
  function automatic logic tf_bijective(input logic [XFORM_W-1:0] t);
    logic [NVARS-1:0] seen;
    seen = '0;
    for (int i = 0; i < NVARS; i++) begin
      seen[tf_perm(t, 2'(i))] = 1'b1;
    end
    tf_bijective = &seen;
  endfunction

  // output and input negation, applied to the table
  function automatic logic [TABLE_W-1:0] tf_negate(input logic [TABLE_W-1:0] f,
                                                  input logic [XFORM_W-1:0] t);
    logic [TABLE_W-1:0] g;
    g = f;
    if (t[0]) g = g ^ MASK_ALL;
    if (t[1]) g = ((g & MASK_V0_H) >> 1) | ((g & MASK_V0_L) << 1);
    if (t[2]) g = ((g & MASK_V1_H) >> 2) | ((g & MASK_V1_L) << 2);
    if (t[3]) g = ((g & MASK_V2_H) >> 4) | ((g & MASK_V2_L) << 4);
    if (t[4]) g = ((g & MASK_V3_H) >> 8) | ((g & MASK_V3_L) << 8);
    tf_negate = g;
  endfunction

  // compose a then b
  function automatic logic [XFORM_W-1:0] tf_compose(input logic [XFORM_W-1:0] a,
                                                   input logic [XFORM_W-1:0] b);
    logic [NVARS-1:0]  neg;
    logic [PERM_W-1:0] perm;
    logic [1:0]        pa;
    for (int i = 0; i < NVARS; i++) begin
      pa            = tf_perm(a, 2'(i));
      neg[i]        = tf_neg(a, 2'(i)) ^ tf_neg(b, pa);
      perm[2*i +: 2] = tf_perm(b, pa);
    end
    tf_compose = {perm, neg, a[0] ^ b[0]};
  endfunction

  // inverse permutation, negations follow their inputs
  function automatic logic [XFORM_W-1:0] tf_invert(input logic [XFORM_W-1:0] a);
    logic [NVARS-1:0]  neg;
    logic [PERM_W-1:0] perm;
    logic [1:0]        pa;
    neg  = '0;
    perm = '0;
    for (int i = 0; i < NVARS; i++) begin
      pa                    = tf_perm(a, 2'(i));
      perm[{pa, 1'b0} +: 2] = 2'(i);
      neg[pa]               = tf_neg(a, 2'(i));
    end
    tf_invert = {perm, neg, a[0]};
  endfunction

endpackage

// ----- hdl/npn_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npn_if
// Valid/ready channels for operation words in and result words out.
// ----------------------------------------------------------------------------
interface npn_in_if;
  import npn_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [TABLE_W-1:0] truth_table;
  logic [XFORM_W-1:0] transform_a;
  logic [XFORM_W-1:0] transform_b;

  modport source (output valid, kind, truth_table, transform_a, transform_b,
                  input ready);
  modport sink   (input valid, kind, truth_table, transform_a, transform_b,
                  output ready);
endinterface

interface npn_out_if;
  import npn_pkg::*;

  logic               valid;
  logic               ready;
  logic [TABLE_W-1:0] result_table;
  logic [XFORM_W-1:0] result_transform;
  logic               perm_invalid;

  modport source (output valid, result_table, result_transform, perm_invalid,
                  input ready);
  modport sink   (input valid, result_table, result_transform, perm_invalid,
                  output ready);
endinterface

// ----- hdl/npn_perm_net.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npn_perm_net
// Scatter network: moves each minterm bit to its permuted index, colliding
// targets are ORed together.
// ----------------------------------------------------------------------------
module npn_perm_net (
  input  logic [npn_pkg::TABLE_W-1:0] table_in,
  input  logic [npn_pkg::PERM_W-1:0]  perm,
  output logic [npn_pkg::TABLE_W-1:0] table_out
);
  import npn_pkg::*;

  logic [NVARS-1:0] dst [TABLE_W];

  // destination index of every minterm
  always_comb begin
    logic [NVARS-1:0] mv;
    for (int m = 0; m < TABLE_W; m++) begin
      mv     = NVARS'(m);
      dst[m] = '0;
      for (int i = 0; i < NVARS; i++) begin
        dst[m][perm[2*i +: 2]] = dst[m][perm[2*i +: 2]] | mv[i];
      end
    end
  end

  // gather per output bit
  always_comb begin
    for (int d = 0; d < TABLE_W; d++) begin
      table_out[d] = 1'b0;
      for (int m = 0; m < TABLE_W; m++) begin
        table_out[d] = table_out[d] | (table_in[m] & (dst[m] == NVARS'(d)));
      end
    end
  end

endmodule

// ----- hdl/npn_transform_unit_4input_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npn_transform_unit_4input_top
// NPN transform unit for 4-input truth tables: apply, compose and invert.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one operation word: kind, truth_table, transform_a and
//          transform_b. A word is taken when valid and ready are both high.
//   out_ch carries one result word per operation: result_table,
//          result_transform and perm_invalid.
//   Three register stages: negation and permutation checks, then the
//   minterm scatter and compose/invert, then result selection into the
//   output register. Throughput is one word per cycle while out_ch.ready
//   is high; the scatter network in stage 2 sets the longest path.
//   Each stage holds its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up and a waiting result does not
//   block new words until all three stages are full.
//   When the receiver stalls, out_ch holds its word unchanged.
//   Synchronous reset clears all valid bits; no word is in flight after it.
// ----------------------------------------------------------------------------
module npn_transform_unit_4input_top (
  input  logic      clk,
  input  logic      rst_n,
  npn_in_if.sink    in_ch,
  npn_out_if.source out_ch
);
  import npn_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic s1_load, s2_load, s3_load;

  logic [TABLE_W-1:0] table_perm;
  logic [TABLE_W-1:0] res_table_r, res_table_nxt;
  logic [XFORM_W-1:0] res_xform_r, res_xform_nxt;
  logic               res_bad_r, res_bad_nxt;

  // per-stage advance
  assign s3_load     = !s3_v_r || out_ch.ready;
  assign s2_load     = !s2_v_r || s3_load;
  assign s1_load     = !s1_v_r || s2_load;
  assign in_ch.ready = s1_load;

  // stage 1: negations and bijection checks
  always_comb begin
    s1_nxt.kind      = in_ch.kind;
    s1_nxt.table_neg = tf_negate(in_ch.truth_table, in_ch.transform_a);
    s1_nxt.xform_a   = in_ch.transform_a;
    s1_nxt.xform_b   = in_ch.transform_b;
    s1_nxt.bad_a     = !tf_bijective(in_ch.transform_a);
    s1_nxt.bad_b     = !tf_bijective(in_ch.transform_b);
  end

  // stage 2: minterm scatter, compose and invert
  npn_perm_net u_perm_net (
    .table_in  (s1_r.table_neg),
    .perm      (s1_r.xform_a[XFORM_W-1 -: PERM_W]),
    .table_out (table_perm)
  );

  always_comb begin
    s2_nxt.kind       = s1_r.kind;
    s2_nxt.table_perm = table_perm;
    s2_nxt.word_comp  = tf_compose(s1_r.xform_a, s1_r.xform_b);
    s2_nxt.word_inv   = tf_invert(s1_r.xform_a);
    s2_nxt.bad_a      = s1_r.bad_a;
    s2_nxt.bad_b      = s1_r.bad_b;
  end

  // stage 3: result selection by kind
  always_comb begin
    res_table_nxt = '0;
    res_xform_nxt = '0;
    res_bad_nxt   = 1'b0;
    case (s2_r.kind)
      KIND_APPLY: begin
        res_table_nxt = s2_r.table_perm;
      end
      KIND_COMPOSE: begin
        res_bad_nxt   = s2_r.bad_a || s2_r.bad_b;
        res_xform_nxt = res_bad_nxt ? '0 : s2_r.word_comp;
      end
      KIND_INVERT: begin
        res_bad_nxt   = s2_r.bad_a;
        res_xform_nxt = res_bad_nxt ? '0 : s2_r.word_inv;
      end
      default: begin
        res_table_nxt = '0;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_load) s1_v_r <= in_ch.valid;
      if (s2_load) s2_v_r <= s1_v_r;
      if (s3_load) s3_v_r <= s2_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load && in_ch.valid) s1_r <= s1_nxt;
    if (s2_load && s1_v_r)      s2_r <= s2_nxt;
    if (s3_load && s2_v_r) begin
      res_table_r <= res_table_nxt;
      res_xform_r <= res_xform_nxt;
      res_bad_r   <= res_bad_nxt;
    end
  end

  assign out_ch.valid            = s3_v_r;
  assign out_ch.result_table     = res_table_r;
  assign out_ch.result_transform = res_xform_r;
  assign out_ch.perm_invalid     = res_bad_r;

endmodule

// ----- hdl/npn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npn_checker
// Port-level checks for the NPN transform unit, bound to the top level.
// ----------------------------------------------------------------------------
module npn_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [npn_pkg::TABLE_W-1:0] out_result_table,
  input logic [npn_pkg::XFORM_W-1:0] out_result_transform,
  input logic                        out_perm_invalid
);
  import npn_pkg::*;

  // nothing in flight right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // a flagged permutation carries an all-zero result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_perm_invalid |-> out_result_table == '0 && out_result_transform == '0)
    else $error("flagged result word is not zero");

  // a nonzero table comes only from apply, which leaves the word and flag clear
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_table != '0 |-> out_result_transform == '0 && !out_perm_invalid)
    else $error("table result mixed with transform result");

  // stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_table)
      && $stable(out_result_transform) && $stable(out_perm_invalid))
    else $error("stalled result word changed");

endmodule

bind npn_transform_unit_4input_top npn_checker u_npn_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_result_table     (out_ch.result_table),
  .out_result_transform (out_ch.result_transform),
  .out_perm_invalid     (out_ch.perm_invalid)
);
